// ----- hw/rtl/lvn3_pkg.sv -----
package lvn3_pkg;

    localparam int unsigned CoordWidth = 32;
    localparam int unsigned HashWidth = 31;
    localparam int unsigned FracWidth = 7;
    localparam int unsigned CornerCount = 8;
    localparam int unsigned LaneDepth = 9;

    localparam logic [31:0] PrimeY = 32'd31337;
    localparam logic [31:0] PrimeZ = 32'd263;
    localparam logic [31:0] PrimeSeed = 32'd1013;
    localparam logic [31:0] MulA = 32'd60493;
    localparam logic [31:0] AddB = 32'd19990303;
    localparam logic [31:0] AddC = 32'd1376312589;
    localparam int unsigned XorShift = 13;

    localparam logic [2:0] TopScale = 3'd7;
    localparam logic [3:0] MaxSetting = 4'd8;
    localparam logic [3:0] ResetSetting = 4'd6;

    localparam logic CfgSeed = 1'b0;
    localparam logic CfgOctave = 1'b1;

    typedef struct packed {
        logic                 valid;
        logic                 first;
        logic                 last;
        logic                 zero;
        logic [2:0]           k;
        logic [FracWidth-1:0] dx;
        logic [FracWidth-1:0] dy;
        logic [FracWidth-1:0] dz;
    } lane_t;

    function automatic logic [31:0] corner_offset(input logic [2:0] idx);
        logic [31:0] off;
        off = {31'd0, idx[0]};
        if (idx[1])
        begin
            off = off + PrimeY;
        end
        if (idx[2])
        begin
            off = off + PrimeZ;
        end
        return off;
    endfunction

endpackage

// ----- hw/rtl/lattice_value_noise_3d_top.sv -----
// A sample passes through the pipeline P times before it reaches the output register,
// where P = max(1, min(octave_setting, 8) - 1) is its number of octave passes.
// The issue stage sends one octave pass per cycle, unless the output stalls, through a
// 9-stage pipeline of eight corner hash units; a new sample is taken as its last pass issues.
// A stalled output freezes the whole pipeline; nothing is lost or repeated.
// Reset (rst_n low, asynchronous): pipeline empty, seed 0, octave setting 6.
module lattice_value_noise_3d_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [31:0] cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [95:0] s_axis_tdata,   // coord_x, coord_y, coord_z
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata    // noise_value
);

    localparam int unsigned Fw = lvn3_pkg::FracWidth;

    logic [31:0] seed_mul_reg;
    logic [3:0]  setting_reg;

    logic        en;
    logic        accept;
    logic [3:0]  setting_sat;
    logic        setting_zero;
    logic [2:0]  k_start;

    logic        iss_valid_reg;
    logic        iss_first_reg;
    logic        iss_zero_reg;
    logic [2:0]  iss_k_reg;
    logic [31:0] iss_x_reg;
    logic [31:0] iss_y_reg;
    logic [31:0] iss_z_reg;
    logic        iss_last;

    lvn3_pkg::lane_t lane_reg [lvn3_pkg::LaneDepth];
    lvn3_pkg::lane_t lane_head;

    logic [31:0] cx_w;
    logic [31:0] cy_w;
    logic [31:0] cz_w;
    logic [Fw-1:0] frac_mask;
    logic [31:0] px_reg;
    logic [31:0] py_reg;
    logic [31:0] pz_reg;
    logic [31:0] base_reg;

    logic [lvn3_pkg::HashWidth-1:0] hash_w [lvn3_pkg::CornerCount];
    logic [13:0] c_w [lvn3_pkg::CornerCount];
    logic [4:0]  hash_shift;

    logic [7:0]  one_z;
    logic [7:0]  iz_w;
    logic [21:0] zi_reg [4];
    logic [7:0]  one_y;
    logic [7:0]  iy_w;
    logic [29:0] y0_reg;
    logic [29:0] y1_reg;
    logic [7:0]  one_x;
    logic [7:0]  ix_w;
    logic [37:0] v_w;
    logic [37:0] v_shift;
    logic [15:0] contrib_next;
    logic [15:0] contrib_reg;

    logic [15:0] acc_reg;
    logic [15:0] sum_w;
    logic        out_valid_reg;
    logic [15:0] out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_mul_reg <= 32'd0;
            setting_reg  <= lvn3_pkg::ResetSetting;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                lvn3_pkg::CfgSeed:   seed_mul_reg <= cfg_wdata * lvn3_pkg::PrimeSeed;
                lvn3_pkg::CfgOctave: setting_reg <= cfg_wdata[3:0];
                default:             setting_reg <= setting_reg;
            endcase
        end
    end

    assign en = !out_valid_reg || m_axis_tready;
    assign iss_last = iss_zero_reg || (iss_k_reg == lvn3_pkg::TopScale);
    assign s_axis_tready = en && (!iss_valid_reg || iss_last);
    assign accept = s_axis_tvalid && s_axis_tready;

    assign setting_sat = (setting_reg > lvn3_pkg::MaxSetting) ? lvn3_pkg::MaxSetting
                                                              : setting_reg;
    assign setting_zero = setting_sat < 4'd2;
    assign k_start = 3'(4'd9 - setting_sat);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            iss_valid_reg <= 1'b0;
            iss_first_reg <= 1'b0;
            iss_zero_reg  <= 1'b0;
            iss_k_reg     <= 3'd0;
        end
        else if (accept)
        begin
            iss_valid_reg <= 1'b1;
            iss_first_reg <= 1'b1;
            iss_zero_reg  <= setting_zero;
            iss_k_reg     <= setting_zero ? lvn3_pkg::TopScale : k_start;
        end
        else if (en && iss_valid_reg)
        begin
            iss_first_reg <= 1'b0;
            if (iss_last)
            begin
                iss_valid_reg <= 1'b0;
            end
            else
            begin
                iss_k_reg <= iss_k_reg + 3'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            iss_x_reg <= s_axis_tdata[31:0];
            iss_y_reg <= s_axis_tdata[63:32];
            iss_z_reg <= s_axis_tdata[95:64];
        end
    end

    assign frac_mask = Fw'((8'd1 << iss_k_reg) - 8'd1);
    assign cx_w = $unsigned($signed(iss_x_reg) >>> iss_k_reg);
    assign cy_w = $unsigned($signed(iss_y_reg) >>> iss_k_reg);
    assign cz_w = $unsigned($signed(iss_z_reg) >>> iss_k_reg);

    always_comb
    begin
        lane_head.valid = iss_valid_reg;
        lane_head.first = iss_first_reg;
        lane_head.last  = iss_last;
        lane_head.zero  = iss_zero_reg;
        lane_head.k     = iss_k_reg;
        lane_head.dx    = iss_x_reg[Fw-1:0] & frac_mask;
        lane_head.dy    = iss_y_reg[Fw-1:0] & frac_mask;
        lane_head.dz    = iss_z_reg[Fw-1:0] & frac_mask;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < lvn3_pkg::LaneDepth; i++)
            begin
                lane_reg[i] <= '0;
            end
        end
        else if (en)
        begin
            lane_reg[0] <= lane_head;
            for (int i = 1; i < lvn3_pkg::LaneDepth; i++)
            begin
                lane_reg[i] <= lane_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            px_reg   <= cx_w;
            py_reg   <= cy_w * lvn3_pkg::PrimeY;
            pz_reg   <= cz_w * lvn3_pkg::PrimeZ;
            base_reg <= px_reg + py_reg + pz_reg + seed_mul_reg;
        end
    end

    for (genvar g = 0; g < lvn3_pkg::CornerCount; g++)
    begin : g_corner
        lvn3_corner_hash u_hash (
            .clk    (clk),
            .en     (en),
            .base   (base_reg),
            .offset (lvn3_pkg::corner_offset(3'(g))),
            .hash   (hash_w[g])
        );
        logic [lvn3_pkg::HashWidth-1:0] sh_w;
        assign sh_w = hash_w[g] >> hash_shift;
        assign c_w[g] = sh_w[13:0];
    end

    assign hash_shift = {2'b00, lane_reg[5].k} + 5'd16;

    assign one_z = 8'd1 << lane_reg[5].k;
    assign iz_w = one_z - {1'b0, lane_reg[5].dz};
    assign one_y = 8'd1 << lane_reg[6].k;
    assign iy_w = one_y - {1'b0, lane_reg[6].dy};
    assign one_x = 8'd1 << lane_reg[7].k;
    assign ix_w = one_x - {1'b0, lane_reg[7].dx};

    assign v_w = {8'd0, y1_reg} * {31'd0, lane_reg[7].dx}
               + {8'd0, y0_reg} * {30'd0, ix_w};
    assign v_shift = v_w >> {lane_reg[7].k, 1'b0};
    assign contrib_next = lane_reg[7].zero ? 16'd0
                        : (v_shift[15:0] >> (4'd8 - {1'b0, lane_reg[7].k}));

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int j = 0; j < 4; j++)
            begin
                zi_reg[j] <= {15'd0, lane_reg[5].dz} * {8'd0, c_w[j+4]}
                           + {14'd0, iz_w} * {8'd0, c_w[j]};
            end
            y0_reg <= {23'd0, lane_reg[6].dy} * {8'd0, zi_reg[2]}
                    + {22'd0, iy_w} * {8'd0, zi_reg[0]};
            y1_reg <= {23'd0, lane_reg[6].dy} * {8'd0, zi_reg[3]}
                    + {22'd0, iy_w} * {8'd0, zi_reg[1]};
            contrib_reg <= contrib_next;
        end
    end

    assign sum_w = (lane_reg[8].first ? 16'd0 : acc_reg) + contrib_reg;

    always_ff @(posedge clk)
    begin
        if (en && lane_reg[8].valid)
        begin
            acc_reg <= sum_w;
            if (lane_reg[8].last)
            begin
                out_data_reg <= sum_w;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en && lane_reg[8].valid && lane_reg[8].last)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata = out_data_reg;

    a_accept_free: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> (!iss_valid_reg || iss_last))
        else $error("sample accepted while octaves still issuing");

    a_zero_contrib: assert property (@(posedge clk) disable iff (!rst_n)
        (en && lane_reg[7].valid && lane_reg[7].zero) |=> (contrib_reg == 16'd0))
        else $error("empty octave pass added a nonzero term");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!en && !accept) |=> ($stable(iss_k_reg) && $stable(lane_reg[8])))
        else $error("pipeline moved during output stall");

    a_zero_last: assert property (@(posedge clk) disable iff (!rst_n)
        (lane_reg[8].valid && lane_reg[8].zero) |-> (lane_reg[8].first && lane_reg[8].last))
        else $error("empty pass not a single-pass sample");

endmodule

// ----- hw/rtl/lvn3_corner_hash.sv -----
module lvn3_corner_hash (
    input  logic                             clk,
    input  logic                             en,
    input  logic [31:0]                      base,
    input  logic [31:0]                      offset,
    output logic [lvn3_pkg::HashWidth-1:0]   hash
);

    logic [31:0]                    sum_w;
    logic [lvn3_pkg::HashWidth-1:0] n0_w;
    logic [lvn3_pkg::HashWidth-1:0] n_a_reg;
    logic [lvn3_pkg::HashWidth-1:0] n_b_reg;
    logic [lvn3_pkg::HashWidth-1:0] n_c_reg;
    logic [31:0]                    sq_reg;
    logic [31:0]                    t_reg;
    logic [lvn3_pkg::HashWidth-1:0] h_reg;
    logic [31:0]                    sq_next;
    logic [31:0]                    t_next;
    logic [31:0]                    h_next;

    assign sum_w = base + offset;
    assign n0_w = sum_w[lvn3_pkg::HashWidth-1:0];
    assign sq_next = {1'b0, n_a_reg} * {1'b0, n_a_reg};
    assign t_next = sq_reg * lvn3_pkg::MulA + lvn3_pkg::AddB;
    assign h_next = {1'b0, n_c_reg} * t_reg + lvn3_pkg::AddC;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            n_a_reg <= n0_w ^ (n0_w >> lvn3_pkg::XorShift);
            sq_reg  <= sq_next;
            n_b_reg <= n_a_reg;
            t_reg   <= t_next;
            n_c_reg <= n_b_reg;
            h_reg   <= h_next[lvn3_pkg::HashWidth-1:0];
        end
    end

    assign hash = h_reg;

endmodule

// ----- tb/tb_lattice_value_noise_3d_top.sv -----
`timescale 1ns / 100ps

class noise_scoreboard;
    bit [15:0] pending_noise[$];
    int        error_count;
    int        checked_count;

    function void note_sample(bit [15:0] noise);
        pending_noise.push_back(noise);
    endfunction

    function void check_noise(bit [15:0] actual);
        bit [15:0] want;
        if (pending_noise.size() == 0)
        begin
            $display("%0t: unexpected result, expected none, actual %h", $time, actual);
            error_count++;
            return;
        end
        want = pending_noise.pop_front();
        checked_count++;
        if (want !== actual)
        begin
            $display("%0t: noise_value mismatch, expected %h, actual %h", $time, want, actual);
            error_count++;
        end
    endfunction
endclass

module tb_lattice_value_noise_3d_top;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic        cfg_index;
    logic [31:0] cfg_wdata;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [95:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;

    logic [31:0] model_seed;
    logic [3:0]  model_setting;
    int          sent_count;
    int          idle_cycles;
    bit          hold_off;
    bit          stim_done;
    noise_scoreboard board;

    lattice_value_noise_3d_top dut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata), .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready), .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    function automatic logic [30:0] corner_hash(logic [31:0] x, logic [31:0] y, logic [31:0] z);
        logic [31:0] n;
        n = (x + lvn3_pkg::PrimeY * y + lvn3_pkg::PrimeZ * z
             + lvn3_pkg::PrimeSeed * model_seed) & 32'h7fffffff;
        n = n ^ (n >> lvn3_pkg::XorShift);
        n = n * (n * n * lvn3_pkg::MulA + lvn3_pkg::AddB) + lvn3_pkg::AddC;
        return n[30:0];
    endfunction

    function automatic logic [15:0] octave_value(logic [31:0] x, logic [31:0] y,
                                                 logic [31:0] z, int k);
        logic [63:0] c[8];
        logic [31:0] cx, cy, cz;
        logic [63:0] dx, dy, dz, ix, iy, iz, z0, z1, z2, z3, y0, y1, v;
        logic [31:0] mask;
        mask = (32'd1 << k) - 1;
        cx = $signed(x) >>> k;
        cy = $signed(y) >>> k;
        cz = $signed(z) >>> k;
        dx = x & mask;
        dy = y & mask;
        dz = z & mask;
        ix = (64'd1 << k) - dx;
        iy = (64'd1 << k) - dy;
        iz = (64'd1 << k) - dz;
        for (int i = 0; i < 8; i++)
        begin
            c[i] = {33'd0, corner_hash(cx + i[0], cy + i[1], cz + i[2])} >> (k + 16);
        end
        z0 = dz * c[4] + iz * c[0];
        z1 = dz * c[5] + iz * c[1];
        z2 = dz * c[6] + iz * c[2];
        z3 = dz * c[7] + iz * c[3];
        y0 = dy * z2 + iy * z0;
        y1 = dy * z3 + iy * z1;
        v = (y1 * dx + ix * y0) >> (2 * k);
        return v[15:0];
    endfunction

    function automatic logic [15:0] fractal_noise(logic [95:0] coords);
        logic [15:0] acc;
        int s;
        acc = 0;
        s = (model_setting > lvn3_pkg::MaxSetting) ? lvn3_pkg::MaxSetting : model_setting;
        if (s >= 2)
        begin
            for (int k = 9 - s; k <= 7; k++)
            begin
                acc = acc + (octave_value(coords[31:0], coords[63:32], coords[95:64], k)
                             >> (8 - k));
            end
        end
        return acc;
    endfunction

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    task automatic write_reg(logic idx, logic [31:0] value);
        cfg_we <= 1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 0;
        @(posedge clk);
        if (idx == lvn3_pkg::CfgSeed)
            model_seed = value;
        else
            model_setting = value[3:0];
    endtask

    task automatic drain();
        s_axis_tvalid <= 0;
        while (board.pending_noise.size() != 0)
            @(posedge clk);
        repeat (30) @(posedge clk);
    endtask

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 4))
            0: return $urandom_range(0, 300);
            1: return -$urandom_range(0, 300);
            2: return 32'h7fffff00 + $urandom_range(0, 255);
            3: return 32'h80000000 + $urandom_range(0, 255);
            default: return $urandom;
        endcase
    endfunction

    task automatic send_sample(logic [95:0] coords, bit no_gap);
        int gap;
        gap = no_gap ? 0 : $urandom_range(0, 12);
        if (gap != 0)
        begin
            s_axis_tvalid <= 0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1;
        s_axis_tdata <= coords;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        board.note_sample(fractal_noise(coords));
        sent_count++;
    endtask

    initial
    begin
        board = new();
        rst_n = 0;
        cfg_we = 0;
        cfg_index = 0;
        cfg_wdata = 0;
        s_axis_tvalid = 0;
        s_axis_tdata = 0;
        model_seed = 0;
        model_setting = lvn3_pkg::ResetSetting;
        repeat (10) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        send_sample({32'd0, 32'd0, 32'd0}, 0);
        send_sample({32'h80000000, 32'h7fffffff, 32'hffffffff}, 0);
        send_sample({32'h7fffffff, 32'h80000000, 32'h0000007f}, 0);
        send_sample({32'hffffffff, 32'hffffffff, 32'hffffffff}, 0);
        send_sample({32'hffffff80, 32'h00000080, 32'h7fffff81}, 0);
        drain();
        for (int s = 0; s <= 15; s++)
        begin
            write_reg(lvn3_pkg::CfgOctave, s);
            write_reg(lvn3_pkg::CfgSeed,
                      (s % 3 == 0) ? 32'h80000000 : (s % 3 == 1) ? 32'h7fffffff : 32'hffffffff);
            send_sample({32'h7fffffff, 32'h80000000, 32'h12345678}, 0);
            drain();
        end

        for (int phase = 0; phase < 8; phase++)
        begin
            write_reg(lvn3_pkg::CfgSeed, $urandom);
            write_reg(lvn3_pkg::CfgOctave,
                      (phase == 0) ? 8 : (phase == 1) ? 1 : $urandom_range(0, 15));
            for (int n = 0; n < 250; n++)
            begin
                send_sample({rand_coord(), rand_coord(), rand_coord()},
                            (phase == 3) || ($urandom_range(0, 3) == 0));
            end
            drain();
        end
        stim_done = 1;
    end

    initial
    begin
        int wait_n;
        m_axis_tready = 0;
        hold_off = 0;
        @(posedge rst_n);
        forever
        begin
            if (sent_count > 900 && sent_count < 1000 && !hold_off)
            begin
                hold_off = 1;
                m_axis_tready <= 0;
                repeat (400) @(posedge clk);
            end
            wait_n = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 12) : 0;
            if (wait_n != 0)
            begin
                m_axis_tready <= 0;
                repeat (wait_n) @(posedge clk);
            end
            m_axis_tready <= 1;
            @(posedge clk);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            board.check_noise(m_axis_tdata);
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        idle_cycles = 0;
        stim_done = 0;
        sent_count = 0;
        fork
            begin
                wait (stim_done);
                $display("Ran %0d samples (%0d results checked) over all octave settings",
                         sent_count, board.checked_count);
                $display("and seed extremes, with random stalls and one long output hold-off.");
                if (board.error_count == 0 && board.pending_noise.size() == 0)
                    $display("tb: success");
                else
                    $display("tb: failure");
                $finish;
            end
            begin
                wait (idle_cycles >= 5000);
                $display("tb: failure");
                $finish;
            end
        join
    end
endmodule

// ----- lattice_value_noise_3d_top.f -----
hw/rtl/lvn3_pkg.sv
hw/rtl/lvn3_corner_hash.sv
hw/rtl/lattice_value_noise_3d_top.sv
tb/tb_lattice_value_noise_3d_top.sv
